FILE: rtl/keyboard_scancode_translator_defines.svh
// Assertion macros for the keyboard scan code translator.
// Taken in by the top level; no other dependencies.
`ifndef KEYBOARD_SCANCODE_TRANSLATOR_DEFINES_SVH
`define KEYBOARD_SCANCODE_TRANSLATOR_DEFINES_SVH

// same-cycle implication
`define KST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/kst_pkg.sv
// Shared types, scan code constants and translation ROMs for the
// keyboard scan code translator. No dependencies.
package kst_pkg;

	localparam int ROM_LEN = 84;

	localparam logic [7:0] NO_MAP    = 8'h80;
	localparam logic [7:0] CTRL_MASK = 8'h1F;
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_O      = 8'h4F;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_B      = 8'h42;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_D      = 8'h44;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_2      = 8'h32;
	localparam logic [7:0] CH_3      = 8'h33;
	localparam logic [7:0] CH_5      = 8'h35;
	localparam logic [7:0] CH_6      = 8'h36;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_Z  = 8'h7A;

	localparam logic [7:0] SC_LSHIFT     = 8'h2A;
	localparam logic [7:0] SC_RSHIFT     = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
	localparam logic [7:0] SC_PREFIX     = 8'hE0;
	localparam logic [7:0] SC_CTRL       = 8'h1D;
	localparam logic [7:0] SC_CTRL_BRK   = 8'h9D;
	localparam logic [7:0] SC_ALT        = 8'h38;
	localparam logic [7:0] SC_ALT_BRK    = 8'hB8;
	localparam logic [7:0] SC_CAPS       = 8'h3A;
	localparam logic [7:0] SC_NUM        = 8'h45;
	localparam logic [7:0] SC_CAPS_BRK   = 8'hBA;
	localparam logic [7:0] SC_NUM_BRK    = 8'hC5;
	localparam logic [7:0] SC_F1         = 8'd59;
	localparam logic [7:0] SC_F9         = 8'd67;
	localparam logic [7:0] SC_F10        = 8'd68;
	localparam logic [7:0] SC_F11        = 8'd87;
	localparam logic [7:0] SC_F12        = 8'd88;
	localparam logic [7:0] SC_HOME       = 8'd71;
	localparam logic [7:0] SC_UP         = 8'd72;
	localparam logic [7:0] SC_PGUP       = 8'd73;
	localparam logic [7:0] SC_LEFT       = 8'd75;
	localparam logic [7:0] SC_PAD5       = 8'd76;
	localparam logic [7:0] SC_RIGHT      = 8'd77;
	localparam logic [7:0] SC_END        = 8'd79;
	localparam logic [7:0] SC_DOWN       = 8'd80;
	localparam logic [7:0] SC_PGDN       = 8'd81;
	localparam logic [7:0] SC_INS        = 8'd82;
	localparam logic [7:0] SC_DEL        = 8'd83;

	localparam logic KIND_CHAR   = 1'b0;
	localparam logic KIND_SCREEN = 1'b1;

	// one queued job: up to four result bytes or a screen select
	typedef struct packed {
		logic            kind;
		logic [3:0]      screen;
		logic [1:0]      last_idx;
		logic [3:0][7:0] bytes;
	} job_t;

	localparam logic [7:0] ROM_PLAIN [ROM_LEN] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h80,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
		8'h6C, 8'h3B, 8'h27, 8'h60, 8'h80,
		8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D,
		8'h2C, 8'h2E, 8'h2F, 8'h80,
		8'h2A, 8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
		8'h80, 8'h80, 8'h80, 8'h80,
		8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
		8'h80, 8'h80, 8'h80, 8'h80,
		8'h80, 8'h80, 8'h80, 8'h30, 8'h7F
	};

	localparam logic [7:0] ROM_UPPER [ROM_LEN] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
		8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h80,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
		8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h80,
		8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D,
		8'h3C, 8'h3E, 8'h3F, 8'h80,
		8'h2A, 8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
		8'h80, 8'h80, 8'h80, 8'h80,
		8'h80, 8'h80, 8'h80, 8'h80, 8'h37, 8'h38, 8'h39, 8'h80,
		8'h34, 8'h35, 8'h36, 8'h80,
		8'h31, 8'h32, 8'h33, 8'h30, 8'h7F
	};

	// codes past the table read as unmapped
	function automatic logic [7:0] rom_plain_rd(input logic [7:0] code);
		logic [7:0] v;
		v = NO_MAP;
		if (code < 8'(ROM_LEN))
			v = ROM_PLAIN[code[6:0]];
		return v;
	endfunction

	function automatic logic [7:0] rom_upper_rd(input logic [7:0] code);
		logic [7:0] v;
		v = NO_MAP;
		if (code < 8'(ROM_LEN))
			v = ROM_UPPER[code[6:0]];
		return v;
	endfunction

endpackage

FILE: rtl/keyboard_scancode_translator.sv
// PC set-1 scan code translator: scan code beats in, character or screen
// select beats out. Depends on kst_pkg, kst_front, kst_queue, kst_back.
//
// Input channel: scan_code with in_valid/in_stall; a beat is taken when
// in_valid is high and in_stall low. in_stall rises only while the job
// queue is full, so a scan code is accepted every cycle otherwise.
// Output channel: result_kind, out_char, screen_index, last_of_run with
// out_valid/out_stall. One scan code gives zero to four result beats;
// last_of_run marks the final one. Codes that give nothing (modifiers,
// break codes, unmapped keys) are accepted but emit no beat.
// Path: a scan code's job is written into the queue when the code is
// accepted, then its result bytes are loaded into the output register one
// beat per cycle while out_stall is low, since the back end has a single-byte
// output register.
// Stalls: while out_stall is high the output beat holds; the queue of
// QUEUE_DEPTH jobs keeps taking scan codes until it fills.
// Reset: all flags, the caps lock enable register and the queue clear at
// once; there is no clearing pass.
// cfg_wr_en writes cfg_wr_data into the caps lock enable register.
`include "keyboard_scancode_translator_defines.svh"

module keyboard_scancode_translator #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] scan_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       result_kind,
	output logic [7:0] out_char,
	output logic [3:0] screen_index,
	output logic       last_of_run
);

	kst_pkg::job_t wr_job, head;
	logic accept, push, pop, empty, full;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	kst_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.accept      (accept),
		.scan_code   (scan_code),
		.push        (push),
		.job         (wr_job)
	);

	kst_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full)
	);

	kst_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.out_char     (out_char),
		.screen_index (screen_index),
		.last_of_run  (last_of_run)
	);

	// a run never breaks: the rest of the job is already queued
	`KST_ASSERT_NEXT(a_run_continues, clk, arst_n, out_valid && !out_stall && !last_of_run, out_valid && result_kind == kst_pkg::KIND_CHAR, "result run broken before its last beat")
	// an escape that is not the last beat opens a sequence
	`KST_ASSERT_NEXT(a_esc_sequence, clk, arst_n, out_valid && !out_stall && !last_of_run && out_char == kst_pkg::CH_ESC, out_char == kst_pkg::CH_O || out_char == kst_pkg::CH_LBRK, "escape not followed by O or [")
	// a screen select stands alone
	`KST_ASSERT_NOW(a_screen_single, clk, arst_n, out_valid && result_kind == kst_pkg::KIND_SCREEN, last_of_run && out_char == 8'd0 && screen_index < 4'd10, "malformed screen select beat")

endmodule

FILE: rtl/kst_front.sv
// Front end: takes scan code beats, tracks modifier and lock flags and
// turns each code that yields output into a queued job. Depends on kst_pkg.
module kst_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic          cfg_wr_data,
	input  logic          accept,
	input  logic [7:0]    scan_code,
	output logic          push,
	output kst_pkg::job_t job
);

	logic caps_en_q;
	logic shift_q, ctrl_q, alt_q, caps_q, num_q, prefix_q;
	logic shift_d, ctrl_d, alt_d, caps_d, num_d, prefix_d;
	logic is_mod, pad, has;
	logic [7:0] fn_off, ch_plain, ch_upper, ch;

	always_comb begin
		shift_d  = shift_q;
		ctrl_d   = ctrl_q;
		alt_d    = alt_q;
		caps_d   = caps_q;
		num_d    = num_q;
		prefix_d = prefix_q;
		is_mod   = 1'b1;
		has      = 1'b0;
		job      = '0;
		pad      = !prefix_q && (num_q ^ shift_q);
		fn_off   = scan_code - kst_pkg::SC_F1;
		ch_plain = kst_pkg::rom_plain_rd(scan_code);
		ch_upper = kst_pkg::rom_upper_rd(scan_code);

		// caps swaps case on letters only
		if (caps_q && ch_plain >= kst_pkg::CH_LOW_A && ch_plain <= kst_pkg::CH_LOW_Z)
			ch = shift_q ? ch_plain : ch_upper;
		else
			ch = shift_q ? ch_upper : ch_plain;

		priority if (alt_q && scan_code >= kst_pkg::SC_F1 && scan_code <= kst_pkg::SC_F10) begin
			// screen select leaves the prefix flag alone
			has        = 1'b1;
			job.kind   = kst_pkg::KIND_SCREEN;
			job.screen = fn_off[3:0];
		end else begin
			unique case (scan_code)
				kst_pkg::SC_LSHIFT, kst_pkg::SC_RSHIFT: shift_d = 1'b1;
				kst_pkg::SC_LSHIFT_BRK, kst_pkg::SC_RSHIFT_BRK: shift_d = 1'b0;
				kst_pkg::SC_PREFIX: prefix_d = 1'b1;
				kst_pkg::SC_CTRL: ctrl_d = 1'b1;
				kst_pkg::SC_CTRL_BRK: ctrl_d = 1'b0;
				kst_pkg::SC_ALT: alt_d = 1'b1;
				kst_pkg::SC_ALT_BRK: alt_d = 1'b0;
				kst_pkg::SC_CAPS, kst_pkg::SC_NUM: ;
				kst_pkg::SC_CAPS_BRK: if (caps_en_q) caps_d = !caps_q;
				kst_pkg::SC_NUM_BRK: num_d = !num_q;
				default: is_mod = 1'b0;
			endcase

			if (scan_code != kst_pkg::SC_PREFIX)
				prefix_d = 1'b0;

			if (!is_mod && !scan_code[7]) begin
				job.kind = kst_pkg::KIND_CHAR;
				unique case (scan_code)
					kst_pkg::SC_UP, kst_pkg::SC_DOWN, kst_pkg::SC_RIGHT,
					kst_pkg::SC_LEFT: begin
						has = 1'b1;
						if (pad) begin
							job.bytes[0] = ch_upper;
						end else begin
							job.last_idx = 2'd2;
							job.bytes[0] = kst_pkg::CH_ESC;
							job.bytes[1] = kst_pkg::CH_O;
							unique case (scan_code)
								kst_pkg::SC_UP:    job.bytes[2] = kst_pkg::CH_A;
								kst_pkg::SC_DOWN:  job.bytes[2] = kst_pkg::CH_B;
								kst_pkg::SC_RIGHT: job.bytes[2] = kst_pkg::CH_C;
								default:           job.bytes[2] = kst_pkg::CH_D;
							endcase
						end
					end
					kst_pkg::SC_PGUP, kst_pkg::SC_PGDN, kst_pkg::SC_INS,
					kst_pkg::SC_DEL: begin
						has = 1'b1;
						if (pad) begin
							job.bytes[0] = ch_upper;
						end else begin
							job.last_idx = 2'd3;
							job.bytes[0] = kst_pkg::CH_ESC;
							job.bytes[1] = kst_pkg::CH_LBRK;
							job.bytes[3] = kst_pkg::CH_TILDE;
							unique case (scan_code)
								kst_pkg::SC_PGUP: job.bytes[2] = kst_pkg::CH_5;
								kst_pkg::SC_PGDN: job.bytes[2] = kst_pkg::CH_6;
								kst_pkg::SC_INS:  job.bytes[2] = kst_pkg::CH_2;
								default:          job.bytes[2] = kst_pkg::CH_3;
							endcase
						end
					end
					kst_pkg::SC_HOME, kst_pkg::SC_PAD5, kst_pkg::SC_END: begin
						// keypad digit or nothing
						has          = pad;
						job.bytes[0] = ch_upper;
					end
					kst_pkg::SC_F10, kst_pkg::SC_F11, kst_pkg::SC_F12: ;
					default: begin
						if (scan_code >= kst_pkg::SC_F1 && scan_code <= kst_pkg::SC_F9) begin
							has          = 1'b1;
							job.last_idx = 2'd2;
							job.bytes[0] = kst_pkg::CH_ESC;
							job.bytes[1] = kst_pkg::CH_O;
							job.bytes[2] = kst_pkg::CH_P + fn_off;
						end else if (ch != kst_pkg::NO_MAP) begin
							has          = 1'b1;
							job.bytes[0] = ctrl_q ? (ch & kst_pkg::CTRL_MASK) : ch;
						end
					end
				endcase
			end
		end
	end

	assign push = accept && has;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caps_en_q <= 1'b0;
			shift_q   <= 1'b0;
			ctrl_q    <= 1'b0;
			alt_q     <= 1'b0;
			caps_q    <= 1'b0;
			num_q     <= 1'b0;
			prefix_q  <= 1'b0;
		end else begin
			if (cfg_wr_en)
				caps_en_q <= cfg_wr_data;
			if (accept) begin
				shift_q  <= shift_d;
				ctrl_q   <= ctrl_d;
				alt_q    <= alt_d;
				caps_q   <= caps_d;
				num_q    <= num_d;
				prefix_q <= prefix_d;
			end
		end
	end

endmodule

FILE: rtl/kst_queue.sv
// Short job queue between front and back ends.
// Depends on kst_pkg for the job type.
module kst_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kst_pkg::job_t wr_job,
	input  logic          pop,
	output kst_pkg::job_t head,
	output logic          empty,
	output logic          full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	kst_pkg::job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign empty   = count_q == '0;
	assign full    = count_q == CNT_W'(DEPTH);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/kst_back.sv
// Back end: walks the head job one byte per beat into the output register.
// Depends on kst_pkg for the job type.
module kst_back (
	input  logic          clk,
	input  logic          arst_n,
	input  kst_pkg::job_t head,
	input  logic          empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          result_kind,
	output logic [7:0]    out_char,
	output logic [3:0]    screen_index,
	output logic          last_of_run
);

	logic       out_valid_q;
	logic [1:0] idx_q;
	logic       take, load, at_end;
	logic       result_kind_q;
	logic [7:0] out_char_q;
	logic [3:0] screen_index_q;
	logic       last_of_run_q;

	assign take   = !out_valid_q || !out_stall;
	assign load   = take && !empty;
	assign at_end = idx_q == head.last_idx;
	assign pop    = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (take)
				out_valid_q <= load;
			if (load)
				idx_q <= at_end ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_kind_q  <= head.kind;
			out_char_q     <= head.bytes[idx_q];
			screen_index_q <= head.screen;
			last_of_run_q  <= at_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = result_kind_q;
	assign out_char     = out_char_q;
	assign screen_index = screen_index_q;
	assign last_of_run  = last_of_run_q;

endmodule
